@@ rtl/ttec_pkg.sv @@
// ----------------------------------------------------------------------------
// ttec_pkg
// Shared types and constants for the transverse thrust engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttec_pkg;

  localparam int MAX_OBJECTS_DEF = 64;
  localparam int COMP_BITS_DEF   = 16;
  localparam int MOM_W           = 16;
  localparam int R2_W            = 32;
  localparam int Q15_FRAC        = 15;
  localparam int RES_W           = 16;
  localparam logic [RES_W-1:0] Q15_ONE = 16'h8000;

  typedef struct packed {
    logic signed [MOM_W-1:0] x;
    logic signed [MOM_W-1:0] y;
  } obj_t;

endpackage

`default_nettype wire

@@ rtl/ttec_cell.sv @@
// ----------------------------------------------------------------------------
// ttec_cell
// One storage cell of the object ring: loads an object or shifts toward head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttec_cell (
  input  wire logic          clk,
  input  wire logic          load_en,
  input  wire logic          rot_en,
  input  wire logic          wrap,
  input  ttec_pkg::obj_t     load_obj,
  input  ttec_pkg::obj_t     next_obj,
  input  ttec_pkg::obj_t     head_obj,
  output ttec_pkg::obj_t     obj
);
  import ttec_pkg::*;

  always_ff @(posedge clk) begin
    if (load_en) begin
      obj <= load_obj;
    end else if (rot_en) begin
      obj <= wrap ? head_obj : next_obj;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ttec_isqrt.sv @@
// ----------------------------------------------------------------------------
// ttec_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttec_isqrt #(
  parameter int SW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [SW-1:0] value,
  output logic               done,
  output logic [SW-1:0]      root
);
  import ttec_pkg::*;

  localparam int STEPS = SW / 2;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic [SW-1:0]   v;
  logic [SW-1:0]   onebit;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [SW-1:0]   trial;

  assign trial = root + onebit;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(STEPS);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v      <= value;
      root   <= '0;
      onebit <= SW'(1) << (SW - 2);
    end else if (run) begin
      if (v >= trial) begin
        v    <= v - trial;
        root <= (root >> 1) + onebit;
      end else begin
        root <= root >> 1;
      end
      onebit <= onebit >> 2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ttec_div.sv @@
// ----------------------------------------------------------------------------
// ttec_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttec_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  import ttec_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   nsh;
  logic [DW-1:0]   d;
  logic [DW-1:0]   rem;
  logic [DW:0]     trial;
  logic [CNTW-1:0] cnt;
  logic            run;

  assign trial = {rem, nsh[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(NW);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      d    <= den;
      rem  <= '0;
      quot <= '0;
    end else if (run) begin
      nsh <= nsh << 1;
      if (trial >= {1'b0, d}) begin
        rem  <= DW'(trial - {1'b0, d});
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= trial[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/transverse_thrust_engine_core.sv @@
// ----------------------------------------------------------------------------
// transverse_thrust_engine_core
// Transverse thrust and minor of a set of objects, using a rotating ring of
// object cells feeding one shared projection MAC.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    mom_x, mom_y, last_object
//   out      source     out_valid/out_ready  thrust_major, thrust_minor,
//                                            empty_set, set_overflow
//
// Each stored object's pT square root completes before the next is accepted.
// On the last object, each nonzero candidate costs two axis divisions and
// square roots plus one ring rotation; then one minor pass and two result
// divisions.
// Reset clears the count, pT sum and flags; the ring needs no clearing.
// Input stalls during computation; the result holds until out_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module transverse_thrust_engine_core #(
  parameter int MAX_OBJECTS = ttec_pkg::MAX_OBJECTS_DEF,
  parameter int COMP_BITS   = ttec_pkg::COMP_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [ttec_pkg::MOM_W-1:0] mom_x,
  input  wire logic signed [ttec_pkg::MOM_W-1:0] mom_y,
  input  wire logic                              last_object,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ttec_pkg::RES_W-1:0]             thrust_major,
  output logic [ttec_pkg::RES_W-1:0]             thrust_minor,
  output logic                                   empty_set,
  output logic                                   set_overflow
);
  import ttec_pkg::*;

  localparam int F    = COMP_BITS - 1;
  localparam int CW   = $clog2(MAX_OBJECTS + 1);
  localparam int PTW  = MOM_W + CW;
  localparam int PW   = MOM_W + COMP_BITS;
  localparam int SUMW = PW + 1 + CW;
  localparam int NW   = (R2_W + 2*F > SUMW + Q15_FRAC) ? R2_W + 2*F : SUMW + Q15_FRAC;
  localparam int DW   = (R2_W > PTW + F) ? R2_W : PTW + F;
  localparam int SW   = (2*F + 2 > R2_W) ? 2*F + 2 : R2_W;
  localparam logic [SW-1:0] MAG_MAX = (SW'(1) << F) - SW'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PTW   = 4'd1;
  localparam logic [3:0] S_CAND  = 4'd2;
  localparam logic [3:0] S_CR2   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_ROT   = 4'd9;
  localparam logic [3:0] S_QMAJ  = 4'd10;
  localparam logic [3:0] S_QMIN  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                 state;
  logic [CW-1:0]              count;
  logic [PTW-1:0]             pt_total;
  logic                       overflow_seen;
  logic                       last_q;
  logic [CW-1:0]              cand;
  logic [CW-1:0]              sum_cnt;
  logic                       comp_sel;
  logic                       phase_minor;
  logic                       found;
  logic [R2_W-1:0]            cx2;
  logic [R2_W-1:0]            cy2;
  logic [R2_W-1:0]            r2c;
  logic signed [COMP_BITS-1:0] nx;
  logic signed [COMP_BITS-1:0] ax;
  logic signed [COMP_BITS-1:0] ay;
  logic signed [COMP_BITS-1:0] bx;
  logic signed [COMP_BITS-1:0] by;
  logic [SUMW-1:0]            best;
  logic [SUMW-1:0]            acc;
  logic                       v1;
  logic signed [PW-1:0]       p1x;
  logic signed [PW-1:0]       p1y;
  logic signed [PW:0]         dsum;
  logic [PW:0]                dabs;
  logic [RES_W-1:0]           major_q;
  logic [RES_W-1:0]           minor_q;

  logic                       sq_start;
  logic [SW-1:0]              sq_val;
  logic                       sq_done;
  logic [SW-1:0]              sq_root;
  logic                       dv_start;
  logic [NW-1:0]              dv_num;
  logic [DW-1:0]              dv_den;
  logic                       dv_done;
  logic [NW-1:0]              dv_quot;

  logic                       in_acc;
  logic                       store_ok;
  logic                       rot_en;
  logic [R2_W-1:0]            r2_in;
  logic [SW-1:0]              mag;
  logic                       comp_neg;
  logic signed [COMP_BITS-1:0] comp;
  logic [RES_W-1:0]           q_sat;
  logic [R2_W-1:0]            r2_sum;

  obj_t cells [MAX_OBJECTS];
  obj_t head;
  obj_t in_obj;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign store_ok  = (count < CW'(MAX_OBJECTS));
  assign rot_en    = (state == S_SUM) || (state == S_ROT);
  assign head      = cells[0];
  assign in_obj    = '{x: mom_x, y: mom_y};
  assign r2_in     = R2_W'(mom_x * mom_x) + R2_W'(mom_y * mom_y);
  assign r2_sum    = cx2 + cy2;

  assign mag      = (sq_root > MAG_MAX) ? MAG_MAX : sq_root;
  assign comp_neg = comp_sel ? head.y[MOM_W-1] : head.x[MOM_W-1];
  assign comp     = comp_neg ? -$signed({1'b0, mag[F-1:0]}) : $signed({1'b0, mag[F-1:0]});
  assign q_sat    = (dv_quot > NW'(Q15_ONE)) ? Q15_ONE : dv_quot[RES_W-1:0];

  assign dsum = {p1x[PW-1], p1x} + {p1y[PW-1], p1y};
  assign dabs = dsum[PW] ? $unsigned(-dsum) : $unsigned(dsum);

  assign thrust_major = major_q;
  assign thrust_minor = minor_q;
  assign empty_set    = !found;
  assign set_overflow = overflow_seen;

  for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_ring
    obj_t nxt;
    if (i == MAX_OBJECTS - 1) begin : g_end
      assign nxt = head;
    end else begin : g_mid
      assign nxt = cells[i+1];
    end
    ttec_cell u_cell (
      .clk      (clk),
      .load_en  (in_acc && store_ok && (count == CW'(i))),
      .rot_en   (rot_en),
      .wrap     ((count - CW'(1)) == CW'(i)),
      .load_obj (in_obj),
      .next_obj (nxt),
      .head_obj (head),
      .obj      (cells[i])
    );
  end

  ttec_isqrt #(.SW(SW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  ttec_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  // projection MAC
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= (state == S_SUM);
    end
  end

  always_ff @(posedge clk) begin
    p1x <= head.x * ax;
    p1y <= head.y * ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      pt_total      <= '0;
      overflow_seen <= 1'b0;
      found         <= 1'b0;
      sq_start      <= 1'b0;
      dv_start      <= 1'b0;
      last_q        <= 1'b0;
      cand          <= '0;
      sum_cnt       <= '0;
      comp_sel      <= 1'b0;
      phase_minor   <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;
      if (v1) begin
        acc <= acc + SUMW'(dabs);
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            last_q <= last_object;
            if (store_ok) begin
              count    <= count + CW'(1);
              sq_val   <= SW'(r2_in);
              sq_start <= 1'b1;
              state    <= S_PTW;
            end else begin
              overflow_seen <= 1'b1;
              if (last_object) begin
                cand  <= '0;
                found <= 1'b0;
                state <= S_CAND;
              end
            end
          end
        end
        S_PTW: begin
          if (sq_done) begin
            pt_total <= pt_total + PTW'(sq_root);
            if (last_q) begin
              cand  <= '0;
              found <= 1'b0;
              state <= S_CAND;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CAND: begin
          if (cand == count) begin
            if (found) begin
              ax          <= by;
              ay          <= -bx;
              phase_minor <= 1'b1;
              sum_cnt     <= '0;
              acc         <= '0;
              state       <= S_SUM;
            end else begin
              major_q <= '0;
              minor_q <= '0;
              state   <= S_OUT;
            end
          end else begin
            cx2   <= R2_W'(head.x * head.x);
            cy2   <= R2_W'(head.y * head.y);
            state <= S_CR2;
          end
        end
        S_CR2: begin
          if (r2_sum == '0) begin
            state <= S_ROT;
          end else begin
            r2c      <= r2_sum;
            dv_num   <= NW'(cx2) << (2*F);
            dv_den   <= DW'(r2_sum);
            dv_start <= 1'b1;
            comp_sel <= 1'b0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            sq_val   <= SW'(dv_quot);
            sq_start <= 1'b1;
            state    <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_done) begin
            if (!comp_sel) begin
              nx       <= comp;
              comp_sel <= 1'b1;
              dv_num   <= NW'(cy2) << (2*F);
              dv_den   <= DW'(r2c);
              dv_start <= 1'b1;
              state    <= S_DIV;
            end else begin
              ax          <= nx;
              ay          <= comp;
              phase_minor <= 1'b0;
              sum_cnt     <= '0;
              acc         <= '0;
              state       <= S_SUM;
            end
          end
        end
        S_SUM: begin
          sum_cnt <= sum_cnt + CW'(1);
          if (sum_cnt == count - CW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (!phase_minor) begin
            if (!found || acc > best) begin
              found <= 1'b1;
              best  <= acc;
              bx    <= ax;
              by    <= ay;
            end
            state <= S_ROT;
          end else begin
            dv_num   <= NW'(best) << Q15_FRAC;
            dv_den   <= DW'(pt_total) << F;
            dv_start <= 1'b1;
            state    <= S_QMAJ;
          end
        end
        S_ROT: begin
          cand  <= cand + CW'(1);
          state <= S_CAND;
        end
        S_QMAJ: begin
          if (dv_done) begin
            major_q  <= q_sat;
            dv_num   <= NW'(acc) << Q15_FRAC;
            dv_start <= 1'b1;
            state    <= S_QMIN;
          end
        end
        S_QMIN: begin
          if (dv_done) begin
            minor_q <= q_sat;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            count         <= '0;
            pt_total      <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ bench/transverse_thrust_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// transverse_thrust_engine_core_tb
// Self-checking bench for the transverse thrust engine. A directed table of
// objects covers empty sets, extreme momenta and tied axes. It is followed by
// random event sets: mostly short, some long, a few past the storage size.
// A bit-accurate thrust predictor tracks every accepted item. Each result is
// checked field by field against the oldest expected one. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transverse_thrust_engine_core_tb;
  import ttec_pkg::*;

  localparam int NOBJ      = MAX_OBJECTS_DEF;
  localparam int FRAC      = COMP_BITS_DEF - 1;
  localparam int N_ITEMS   = 1250;
  localparam int CYC_LIMIT = 4000000;

  typedef struct {
    logic [RES_W-1:0] major;
    logic [RES_W-1:0] minor;
    logic             empty;
    logic             ovf;
  } thrust_res_t;

  typedef struct {
    int          x;
    int          y;
    bit          last;
    bit          typed;
    thrust_res_t res;
  } obj_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [MOM_W-1:0] mom_x = '0;
  logic signed [MOM_W-1:0] mom_y = '0;
  logic                    last_object = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [RES_W-1:0]        thrust_major;
  logic [RES_W-1:0]        thrust_minor;
  logic                    empty_set;
  logic                    set_overflow;

  transverse_thrust_engine_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mom_x(mom_x), .mom_y(mom_y), .last_object(last_object),
    .out_valid(out_valid), .out_ready(out_ready),
    .thrust_major(thrust_major), .thrust_minor(thrust_minor),
    .empty_set(empty_set), .set_overflow(set_overflow)
  );

  always #5 clk = ~clk;

  // predictor state
  longint      obj_x [NOBJ];
  longint      obj_y [NOBJ];
  int          obj_cnt = 0;
  longint      pt_sum = 0;
  bit          ovf_seen = 0;
  thrust_res_t thrust_q[$];
  bit          cur_typed = 0;
  thrust_res_t cur_res;

  int     errors = 0;
  int     cycles = 0;
  int     sets_done = 0;
  int     ovf_sets = 0;
  int     items_sent = 0;
  bit     quiet = 0;
  int     stall_left = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint c, longint unsigned r2);
    longint unsigned c2, q, rem, mag;
    c2 = c * c;
    q = c2 / r2;
    rem = c2 % r2;
    for (int i = 0; i < 2 * FRAC; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= r2) begin
        rem -= r2;
        q |= 1;
      end
    end
    mag = isqrt(q);
    if (mag > (64'd1 << FRAC) - 1) mag = (64'd1 << FRAC) - 1;
    return c < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned abs_proj_sum(longint nx, longint ny);
    longint unsigned s;
    longint d;
    s = 0;
    for (int k = 0; k < obj_cnt; k++) begin
      d = obj_x[k] * nx + obj_y[k] * ny;
      s += d < 0 ? -d : d;
    end
    return s;
  endfunction

  function automatic logic [RES_W-1:0] frac_q15(longint unsigned s);
    longint unsigned q;
    if (pt_sum == 0) return '0;
    q = s / (longint'(pt_sum) << (FRAC - Q15_FRAC));
    return q > 32768 ? Q15_ONE : q[RES_W-1:0];
  endfunction

  function automatic thrust_res_t thrust_of_set();
    thrust_res_t r;
    bit found;
    longint unsigned best, s, r2;
    longint bx, by, nx, ny;
    found = 0;
    best = 0;
    bx = 0;
    by = 0;
    for (int k = 0; k < obj_cnt; k++) begin
      r2 = obj_x[k] * obj_x[k] + obj_y[k] * obj_y[k];
      if (r2 != 0) begin
        nx = unit_comp(obj_x[k], r2);
        ny = unit_comp(obj_y[k], r2);
        s = abs_proj_sum(nx, ny);
        if (!found || s > best) begin
          found = 1;
          best = s;
          bx = nx;
          by = ny;
        end
      end
    end
    r.major = found ? frac_q15(best) : '0;
    r.minor = found ? frac_q15(abs_proj_sum(by, -bx)) : '0;
    r.empty = !found;
    r.ovf = ovf_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    thrust_res_t e;
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, thrust_q.size());
      $display("transverse_thrust_engine_core_tb: errors");
      $finish;
    end
    if (!rst && in_valid && in_ready) begin
      if (obj_cnt < NOBJ) begin
        obj_x[obj_cnt] = mom_x;
        obj_y[obj_cnt] = mom_y;
        obj_cnt++;
        pt_sum += isqrt(longint'(mom_x) * mom_x + longint'(mom_y) * mom_y);
      end else begin
        ovf_seen = 1;
      end
      if (last_object) begin
        e = cur_typed ? cur_res : thrust_of_set();
        thrust_q = {thrust_q, e};
        if (ovf_seen) ovf_sets++;
        sets_done++;
        obj_cnt = 0;
        pt_sum = 0;
        ovf_seen = 0;
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (thrust_q.size() == 0) begin
        $display("%0t unexpected result major=%0d minor=%0d empty=%0b ovf=%0b",
                 $time, thrust_major, thrust_minor, empty_set, set_overflow);
        errors++;
      end else begin
        e = thrust_q.pop_front();
        if (thrust_major !== e.major || thrust_minor !== e.minor ||
            empty_set !== e.empty || set_overflow !== e.ovf) begin
          $display("%0t mismatch exp major=%0d minor=%0d empty=%0b ovf=%0b",
                   $time, e.major, e.minor, e.empty, e.ovf);
          $display("%0t          got major=%0d minor=%0d empty=%0b ovf=%0b",
                   $time, thrust_major, thrust_minor, empty_set, set_overflow);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 49) == 0) stall_left <= $urandom_range(10, 200);
    end
  end

  task automatic send_obj(obj_row_t row);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    mom_x = row.x[MOM_W-1:0];
    mom_y = row.y[MOM_W-1:0];
    last_object = row.last;
    cur_typed = row.typed;
    cur_res = row.res;
    in_valid = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    items_sent++;
  endtask

  function automatic int rand_mom(int mode);
    case (mode)
      0: return $urandom_range(0, 2000) - 1000;
      1: return $urandom_range(0, 65535) - 32768;
      2: return 0;
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
  endfunction

  obj_row_t dir_tab[] = '{
    '{0, 0, 1, 1, '{16'd0, 16'd0, 1'b1, 1'b0}},
    '{100, 0, 1, 1, '{16'd32767, 16'd0, 1'b0, 1'b0}},
    '{-32768, -32768, 1, 1, '{Q15_ONE, 16'd0, 1'b0, 1'b0}},
    '{0, -5, 1, 1, '{16'd32767, 16'd0, 1'b0, 1'b0}},
    '{0, 0, 0, 1, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{0, 0, 0, 1, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{0, 0, 1, 1, '{16'd0, 16'd0, 1'b1, 1'b0}},
    '{32767, 0, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{-32768, 0, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{0, 32767, 1, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{50, 50, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{50, 50, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{-50, -50, 1, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{1, -1, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{-1, 1, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{3, 4, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{-32768, 32767, 0, 0, '{16'd0, 16'd0, 1'b0, 1'b0}},
    '{32767, -32768, 1, 0, '{16'd0, 16'd0, 1'b0, 1'b0}}
  };

  initial begin
    obj_row_t row;
    int n, mode, sel, big_sets;
    big_sets = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) send_obj(dir_tab[i]);

    row.typed = 0;
    while (items_sent < N_ITEMS) begin
      quiet = $urandom_range(0, 5) == 0;
      sel = $urandom_range(0, 99);
      if (sel < 4 && big_sets < 6) begin
        n = $urandom_range(60, 70);
        big_sets++;
      end else if (sel < 14) begin
        n = $urandom_range(9, 30);
      end else begin
        n = $urandom_range(1, 8);
      end
      mode = $urandom_range(0, 9);
      for (int k = 0; k < n; k++) begin
        sel = mode < 5 ? 0 : (mode < 8 ? 1 : $urandom_range(0, 3));
        row.x = rand_mom(sel);
        row.y = rand_mom($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : sel);
        row.last = k == n - 1;
        send_obj(row);
      end
    end
    in_valid = 1'b0;
    quiet = 0;

    while (thrust_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d objects in %0d event sets, %0d sets past storage, %0d cycles",
             items_sent, sets_done, ovf_sets, cycles);
    if (errors == 0) begin
      $display("transverse_thrust_engine_core_tb: clean");
    end else begin
      $display("%0d failures", errors);
      $display("transverse_thrust_engine_core_tb: errors");
    end
    $finish;
  end

endmodule
